### design/ffsa_pkg.sv
// ffsa_pkg: shared types and constants for the first-fit segment allocator
// segment record, table write request, shared arithmetic unit types and sequencer states
// no dependencies
`timescale 1ns / 1ps

package ffsa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [ADDR_BITS-1:0] POOL_RESET = ADDR_BITS'(1024);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_SPACE   = 3'd1,
        STAT_NOT_FOUND  = 3'd2,
        STAT_TABLE_FULL = 3'd3,
        STAT_ZERO_SIZE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] length;
        logic                 used;
    } seg_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        seg_t             data;
    } tbl_wr_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] value;
        logic                 borrow;
    } alu_res_t;

    typedef enum logic [3:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_SCAN,
        FSM_ALLOC_CHK,
        FSM_SHIFT_UP,
        FSM_ALLOC_WR,
        FSM_FREE_RDN,
        FSM_FREE_RDP,
        FSM_FREE_GETP,
        FSM_FREE_WR,
        FSM_SHIFT_DN,
        FSM_RESP
    } fsm_t;

endpackage

### design/ffsa_alu.sv
// ffsa_alu: shared add / subtract unit for the scan compares and the end and merge sums
// depends on ffsa_pkg
`timescale 1ns / 1ps

module ffsa_alu
    import ffsa_pkg::*;
(
    input  alu_op_t              op,
    input  logic [ADDR_BITS-1:0] a,
    input  logic [ADDR_BITS-1:0] b,
    output alu_res_t             res
);

    logic [ADDR_BITS:0] wide;

    always_comb
    begin
        case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = '0;
        endcase
        res.value  = wide[ADDR_BITS-1:0];
        // carry out of the add, borrow out of the subtract
        res.borrow = wide[ADDR_BITS];
    end

endmodule

### design/ffsa_table.sv
// ffsa_table: segment table memory, one write port and one registered read port
// depends on ffsa_pkg
`timescale 1ns / 1ps

module ffsa_table
    import ffsa_pkg::*;
(
    input  logic             clk,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output seg_t             rd_data
);

    seg_t mem [MAX_SEGMENTS];
    seg_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/first_fit_segment_allocator_top.sv
// first_fit_segment_allocator_top: sequencer, registers and output stage of the allocator
// depends on ffsa_pkg, ffsa_alu, ffsa_table
//
// usage:
//   input channel (in_valid / in_stall) carries func, request_size and address.
//   func 0 allocates request_size units first-fit, func 1 frees the used segment
//   starting at address and merges it with free neighbors.
//   output channel (out_valid / out_stall) carries status, block_start, block_size,
//   one result per request, in request order.
//   cfg_write / cfg_data set pool_size and reset the table to one free segment;
//   write only while no request is in flight.
// timing:
//   one request at a time; in_stall is high from the transfer until the result is
//   loaded into the output register. the scan reads one entry per cycle through the
//   registered table read port, and an insert or remove moves one entry per cycle.
// reset:
//   pool_size returns to 1024 and the table holds one free segment; after reset
//   (and after each cfg write) the init state writes entry 0, in_stall stays high.
//   a stalled result stays in the output register; the next request is still
//   accepted and waits for it only when its own result is ready.
`timescale 1ns / 1ps

module first_fit_segment_allocator_top
    import ffsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [ADDR_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [ADDR_BITS-1:0] request_size,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [ADDR_BITS-1:0] block_start,
    output logic [ADDR_BITS-1:0] block_size
);

    fsm_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 op_reg, op_next;
    logic [ADDR_BITS-1:0] req_reg, req_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 pend_reg, pend_next;
    logic [CNT_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     end_reg, end_next;
    logic [1:0]           dist_reg, dist_next;
    logic [ADDR_BITS-1:0] seg_start_reg, seg_start_next;
    logic [ADDR_BITS-1:0] acc_reg, acc_next;
    logic [ADDR_BITS-1:0] rest_reg, rest_next;
    logic [ADDR_BITS-1:0] sum_reg, sum_next;
    logic                 merge_next_reg, merge_next_next;
    logic                 merge_prev_reg, merge_prev_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0] out_start_reg, out_start_next;
    logic [ADDR_BITS-1:0] out_size_reg, out_size_next;

    tbl_wr_t              tbl_wr;
    logic [CNT_W-1:0]     rd_ptr;
    seg_t                 tbl_rd;
    alu_op_t              alu_op;
    logic [ADDR_BITS-1:0] alu_a;
    logic [ADDR_BITS-1:0] alu_b;
    alu_res_t             alu_res;

    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     pend_up;
    logic [CNT_W-1:0]     pend_dn;
    logic [CNT_W-1:0]     count_last;
    logic                 out_free;
    logic                 in_xfer;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign pend_up    = pend_idx_reg + CNT_W'(1);
    assign pend_dn    = pend_idx_reg - CNT_W'(dist_reg);
    assign count_last = count_reg - CNT_W'(1);
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != FSM_IDLE);
    assign in_xfer    = in_valid && !in_stall;

    ffsa_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (rd_ptr[IDX_W-1:0]),
        .rd_data (tbl_rd)
    );

    ffsa_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // operand selection for the shared unit
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = tbl_rd.length;
        alu_b  = req_reg;
        case (state_reg)
            FSM_SCAN:
            begin
                alu_op = ALU_SUB;
                if (op_reg == FUNC_ALLOC)
                begin
                    alu_a = tbl_rd.length;
                    alu_b = req_reg;
                end
                else
                begin
                    alu_a = tbl_rd.start;
                    alu_b = addr_reg;
                end
            end
            FSM_ALLOC_CHK:
            begin
                alu_op = ALU_ADD;
                alu_a  = seg_start_reg;
                alu_b  = req_reg;
            end
            FSM_FREE_RDP:
            begin
                alu_op = ALU_ADD;
                alu_a  = acc_reg;
                alu_b  = tbl_rd.length;
            end
            FSM_FREE_GETP:
            begin
                alu_op = ALU_ADD;
                alu_a  = tbl_rd.length;
                alu_b  = acc_reg;
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_INIT;
            pool_reg      <= POOL_RESET;
            count_reg     <= CNT_W'(1);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        idx_reg        <= idx_next;
        end_reg        <= end_next;
        dist_reg       <= dist_next;
        seg_start_reg  <= seg_start_next;
        acc_reg        <= acc_next;
        rest_reg       <= rest_next;
        sum_reg        <= sum_next;
        merge_next_reg <= merge_next_next;
        merge_prev_reg <= merge_prev_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_size_reg   <= out_size_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        pool_next       = pool_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        dist_next       = dist_reg;
        seg_start_next  = seg_start_reg;
        acc_next        = acc_reg;
        rest_next       = rest_reg;
        sum_next        = sum_reg;
        merge_next_next = merge_next_reg;
        merge_prev_next = merge_prev_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_size_next   = out_size_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rd_ptr          = ptr_reg;
        tbl_wr          = '0;

        case (state_reg)
            FSM_INIT:
            begin
                tbl_wr.en          = 1'b1;
                tbl_wr.addr        = '0;
                tbl_wr.data.start  = '0;
                tbl_wr.data.length = pool_reg;
                tbl_wr.data.used   = 1'b0;
                state_next         = FSM_IDLE;
            end

            FSM_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next   = func;
                    req_next  = request_size;
                    addr_next = address;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    if (func == FUNC_ALLOC && request_size == '0)
                    begin
                        res_status_next = STAT_ZERO_SIZE;
                        state_next      = FSM_RESP;
                    end
                    else
                    begin
                        state_next = FSM_SCAN;
                    end
                end
            end

            // one read issued per cycle, compared in the cycle after its issue
            FSM_SCAN:
            begin
                rd_ptr        = ptr_reg;
                pend_next     = (ptr_reg < count_reg);
                pend_idx_next = ptr_reg;
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if ((op_reg == FUNC_ALLOC) ? (!tbl_rd.used && !alu_res.borrow)
                                               : (tbl_rd.used && alu_res.value == '0))
                    begin
                        pend_next      = 1'b0;
                        idx_next       = pend_idx_reg;
                        seg_start_next = tbl_rd.start;
                        acc_next       = tbl_rd.length;
                        rest_next      = alu_res.value;
                        state_next     = (op_reg == FUNC_ALLOC) ? FSM_ALLOC_CHK
                                                                : FSM_FREE_RDN;
                    end
                    else if (pend_idx_reg == count_last)
                    begin
                        pend_next       = 1'b0;
                        res_status_next = (op_reg == FUNC_ALLOC) ? STAT_NO_SPACE
                                                                 : STAT_NOT_FOUND;
                        state_next      = FSM_RESP;
                    end
                end
            end

            FSM_ALLOC_CHK:
            begin
                if (rest_reg != '0 && count_reg == CNT_W'(MAX_SEGMENTS))
                begin
                    res_status_next = STAT_TABLE_FULL;
                    state_next      = FSM_RESP;
                end
                else
                begin
                    tbl_wr.en          = 1'b1;
                    tbl_wr.addr        = idx_reg[IDX_W-1:0];
                    tbl_wr.data.start  = seg_start_reg;
                    tbl_wr.data.length = req_reg;
                    tbl_wr.data.used   = 1'b1;
                    res_status_next    = STAT_OK;
                    sum_next           = alu_res.value;
                    ptr_next           = count_last;
                    pend_next          = 1'b0;
                    state_next         = (rest_reg == '0) ? FSM_RESP : FSM_SHIFT_UP;
                end
            end

            // open a hole at idx + 1, moving entries up from the top down
            FSM_SHIFT_UP:
            begin
                rd_ptr        = ptr_reg;
                pend_next     = (ptr_reg > idx_reg);
                pend_idx_next = ptr_reg;
                if (ptr_reg > idx_reg)
                begin
                    ptr_next = ptr_reg - CNT_W'(1);
                end
                if (pend_reg)
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = pend_up[IDX_W-1:0];
                    tbl_wr.data = tbl_rd;
                end
                if (!(ptr_reg > idx_reg) && !pend_reg)
                begin
                    state_next = FSM_ALLOC_WR;
                end
            end

            FSM_ALLOC_WR:
            begin
                tbl_wr.en          = 1'b1;
                tbl_wr.addr        = idx_inc[IDX_W-1:0];
                tbl_wr.data.start  = sum_reg;
                tbl_wr.data.length = rest_reg;
                tbl_wr.data.used   = 1'b0;
                count_next         = count_reg + CNT_W'(1);
                state_next         = FSM_RESP;
            end

            FSM_FREE_RDN:
            begin
                rd_ptr     = idx_inc;
                state_next = FSM_FREE_RDP;
            end

            FSM_FREE_RDP:
            begin
                rd_ptr          = idx_dec;
                merge_next_next = 1'b0;
                if (idx_inc < count_reg && !tbl_rd.used)
                begin
                    merge_next_next = 1'b1;
                    acc_next        = alu_res.value;
                end
                state_next = FSM_FREE_GETP;
            end

            FSM_FREE_GETP:
            begin
                merge_prev_next = 1'b0;
                if (idx_reg != '0 && !tbl_rd.used)
                begin
                    merge_prev_next = 1'b1;
                    acc_next        = alu_res.value;
                    seg_start_next  = tbl_rd.start;
                end
                state_next = FSM_FREE_WR;
            end

            FSM_FREE_WR:
            begin
                tbl_wr.en          = 1'b1;
                tbl_wr.addr        = merge_prev_reg ? idx_dec[IDX_W-1:0] : idx_reg[IDX_W-1:0];
                tbl_wr.data.start  = seg_start_reg;
                tbl_wr.data.length = acc_reg;
                tbl_wr.data.used   = 1'b0;
                res_status_next    = STAT_OK;
                dist_next          = {1'b0, merge_next_reg} + {1'b0, merge_prev_reg};
                ptr_next           = idx_inc + CNT_W'(merge_next_reg);
                end_next           = count_last;
                count_next         = count_reg - CNT_W'(merge_next_reg)
                                     - CNT_W'(merge_prev_reg);
                pend_next          = 1'b0;
                state_next         = (merge_next_reg || merge_prev_reg) ? FSM_SHIFT_DN
                                                                        : FSM_RESP;
            end

            // close the gap left by merged entries, moving entries down
            FSM_SHIFT_DN:
            begin
                rd_ptr        = ptr_reg;
                pend_next     = (ptr_reg <= end_reg);
                pend_idx_next = ptr_reg;
                if (ptr_reg <= end_reg)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = pend_dn[IDX_W-1:0];
                    tbl_wr.data = tbl_rd;
                end
                if (!(ptr_reg <= end_reg) && !pend_reg)
                begin
                    state_next = FSM_RESP;
                end
            end

            FSM_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    if (res_status_reg != STAT_OK)
                    begin
                        out_start_next = '0;
                        out_size_next  = '0;
                    end
                    else if (op_reg == FUNC_ALLOC)
                    begin
                        out_start_next = seg_start_reg;
                        out_size_next  = req_reg;
                    end
                    else
                    begin
                        out_start_next = seg_start_reg;
                        out_size_next  = acc_reg;
                    end
                    state_next = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_INIT;
            end
        endcase

        // new pool size: table goes back to a single free segment
        if (cfg_write)
        begin
            pool_next  = cfg_data;
            count_next = CNT_W'(1);
            state_next = FSM_INIT;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign block_start = out_start_reg;
    assign block_size  = out_size_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_SHIFT_UP |-> count_reg < CNT_W'(MAX_SEGMENTS))
        else $error("insert started on a full table");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STAT_OK |-> block_start == '0 && block_size == '0)
        else $error("failed result carries a nonzero block");

    a_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !cfg_write |=> state_reg == FSM_SCAN || state_reg == FSM_RESP)
        else $error("request transfer did not start the sequencer");
`endif

endmodule

### test/tb_first_fit_segment_allocator_top.sv
// tb_first_fit_segment_allocator_top: self-checking testbench for the first-fit allocator
// directed and random allocate/free traffic under several pool sizes, checked against a table model
// depends on ffsa_pkg and first_fit_segment_allocator_top
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator_top;
    import ffsa_pkg::*;

    typedef struct {
        status_t              code;
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] units;
    } alloc_result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write    = 1'b0;
    logic [ADDR_BITS-1:0] cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic                 func         = FUNC_ALLOC;
    logic [ADDR_BITS-1:0] request_size = '0;
    logic [ADDR_BITS-1:0] address      = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] block_start;
    logic [ADDR_BITS-1:0] block_size;

    // segment table as the block should hold it
    logic [ADDR_BITS-1:0] tbl_start  [MAX_SEGMENTS];
    logic [ADDR_BITS-1:0] tbl_length [MAX_SEGMENTS];
    logic                 tbl_used   [MAX_SEGMENTS];
    int                   tbl_count;
    logic [ADDR_BITS-1:0] pool_units;

    alloc_result_t pending_results[$];
    alloc_result_t oldest;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            mismatch_count = 0;
    int            result_count = 0;
    int            pool_writes = 0;
    int            status_seen [5] = '{default: 0};

    first_fit_segment_allocator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .request_size (request_size),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .block_start  (block_start),
        .block_size   (block_size)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void clear_table();
        int k;
        for (k = 0; k < MAX_SEGMENTS; k++)
        begin
            tbl_start[k]  = '0;
            tbl_length[k] = '0;
            tbl_used[k]   = 1'b0;
        end
        tbl_length[0] = pool_units;
        tbl_count     = 1;
    endfunction

    function automatic void remove_entry(int pos);
        int k;
        for (k = pos; k + 1 < tbl_count; k++)
        begin
            tbl_start[k]  = tbl_start[k+1];
            tbl_length[k] = tbl_length[k+1];
            tbl_used[k]   = tbl_used[k+1];
        end
        tbl_count--;
        tbl_start[tbl_count]  = '0;
        tbl_length[tbl_count] = '0;
        tbl_used[tbl_count]   = 1'b0;
    endfunction

    // applies one request to the table and returns the result the block owes
    function automatic alloc_result_t predict_request(logic f, logic [ADDR_BITS-1:0] sz,
                                                      logic [ADDR_BITS-1:0] ad);
        alloc_result_t        r;
        int                   hit;
        int                   k;
        logic [ADDR_BITS-1:0] rest;
        r.code  = STAT_OK;
        r.base  = '0;
        r.units = '0;
        hit     = -1;
        if (f == FUNC_ALLOC)
        begin
            if (sz == 0)
                r.code = STAT_ZERO_SIZE;
            else
            begin
                for (k = 0; k < tbl_count; k++)
                    if (hit < 0 && !tbl_used[k] && tbl_length[k] >= sz)
                        hit = k;
                if (hit < 0)
                    r.code = STAT_NO_SPACE;
                else
                begin
                    rest = tbl_length[hit] - sz;
                    if (rest != 0 && tbl_count >= MAX_SEGMENTS)
                        r.code = STAT_TABLE_FULL;
                    else
                    begin
                        if (rest != 0)
                        begin
                            for (k = tbl_count; k > hit + 1; k--)
                            begin
                                tbl_start[k]  = tbl_start[k-1];
                                tbl_length[k] = tbl_length[k-1];
                                tbl_used[k]   = tbl_used[k-1];
                            end
                            tbl_count++;
                            tbl_start[hit+1]  = tbl_start[hit] + sz;
                            tbl_length[hit+1] = rest;
                            tbl_used[hit+1]   = 1'b0;
                        end
                        tbl_used[hit]   = 1'b1;
                        tbl_length[hit] = sz;
                        r.base  = tbl_start[hit];
                        r.units = sz;
                    end
                end
            end
        end
        else
        begin
            for (k = 0; k < tbl_count; k++)
                if (hit < 0 && tbl_used[k] && tbl_start[k] == ad)
                    hit = k;
            if (hit < 0)
                r.code = STAT_NOT_FOUND;
            else
            begin
                tbl_used[hit] = 1'b0;
                if (hit + 1 < tbl_count && !tbl_used[hit+1])
                begin
                    tbl_length[hit] = tbl_length[hit] + tbl_length[hit+1];
                    remove_entry(hit + 1);
                end
                if (hit > 0 && !tbl_used[hit-1])
                begin
                    tbl_length[hit-1] = tbl_length[hit-1] + tbl_length[hit];
                    remove_entry(hit);
                    hit--;
                end
                r.base  = tbl_start[hit];
                r.units = tbl_length[hit];
            end
        end
        return r;
    endfunction

    // called at a rising edge; returns at the edge where the transfer happened
    task automatic send_request(logic f, logic [ADDR_BITS-1:0] sz, logic [ADDR_BITS-1:0] ad);
        pending_results.push_back(predict_request(f, sz, ad));
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        request_size <= sz;
        address      <= ad;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool_size(logic [ADDR_BITS-1:0] units);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= units;
        @(posedge clk);
        cfg_write <= 1'b0;
        pool_units = units;
        clear_table();
        pool_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (status < 5)
                status_seen[status]++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d start %0d size %0d",
                         $time, status, block_start, block_size);
                mismatch_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (status !== oldest.code)
                begin
                    $display("%0t: status expected %0d (%s) actual %0d", $time,
                             oldest.code, oldest.code.name(), status);
                    mismatch_count++;
                end
                if (block_start !== oldest.base)
                begin
                    $display("%0t: block_start expected %0d actual %0d", $time,
                             oldest.base, block_start);
                    mismatch_count++;
                end
                if (block_size !== oldest.units)
                begin
                    $display("%0t: block_size expected %0d actual %0d", $time,
                             oldest.units, block_size);
                    mismatch_count++;
                end
            end
        end
    end

    // reset pool: splits, exact fit, misses, and a merge on both sides
    task automatic test_basic_ops();
        send_request(FUNC_ALLOC, 16'd0, 16'hffff);
        send_request(FUNC_ALLOC, 16'd1025, 16'd0);
        send_request(FUNC_ALLOC, 16'd100, 16'd0);
        send_request(FUNC_ALLOC, 16'd200, 16'd0);
        send_request(FUNC_ALLOC, 16'd724, 16'd0);
        send_request(FUNC_ALLOC, 16'd1, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd50);
        send_request(FUNC_FREE, 16'hffff, 16'hffff);
        send_request(FUNC_FREE, 16'd0, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd300);
        send_request(FUNC_FREE, 16'd0, 16'd100);
        send_request(FUNC_FREE, 16'd0, 16'd100);
        drain_results();
    endtask

    // empty pool, full-width pool and single-unit pool
    task automatic test_pool_extremes();
        write_pool_size(16'd0);
        send_request(FUNC_ALLOC, 16'd1, 16'd0);
        send_request(FUNC_ALLOC, 16'd0, 16'd0);
        send_request(FUNC_ALLOC, 16'hffff, 16'd0);
        write_pool_size(16'hffff);
        send_request(FUNC_ALLOC, 16'hffff, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd0);
        write_pool_size(16'd1);
        send_request(FUNC_ALLOC, 16'd1, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd0);
        drain_results();
    endtask

    // mostly legal allocate/free traffic on the current table, some noise
    task automatic pick_request(output logic f, output logic [ADDR_BITS-1:0] sz,
                                output logic [ADDR_BITS-1:0] ad);
        int pick;
        int n_used;
        int n_free;
        int target;
        int k;
        int seen;
        int hi;
        sz     = ADDR_BITS'($urandom);
        ad     = ADDR_BITS'($urandom);
        n_used = 0;
        for (k = 0; k < tbl_count; k++)
            if (tbl_used[k])
                n_used++;
        n_free = tbl_count - n_used;
        pick   = $urandom_range(99);
        if (pick < 52)
        begin
            f  = FUNC_ALLOC;
            hi = (pool_units / 16 > 1) ? pool_units / 16 : 1;
            case ($urandom_range(9))
                6:
                begin
                    target = $urandom_range(n_free - 1, 0);
                    seen   = 0;
                    for (k = 0; k < tbl_count; k++)
                        if (!tbl_used[k])
                        begin
                            if (seen == target)
                                sz = tbl_length[k];
                            seen++;
                        end
                end
                7: ;
                8: sz = '0;
                9: sz = ADDR_BITS'($urandom_range(pool_units > 0 ? pool_units : 1, 1));
                default: sz = ADDR_BITS'($urandom_range(hi, 1));
            endcase
        end
        else
        begin
            f = FUNC_FREE;
            if (pick < 90 && n_used > 0)
            begin
                target = $urandom_range(n_used - 1, 0);
                seen   = 0;
                for (k = 0; k < tbl_count; k++)
                    if (tbl_used[k])
                    begin
                        if (seen == target)
                            ad = tbl_start[k];
                        seen++;
                    end
            end
            else if (pick < 94)
            begin
                // start of a free segment, or one past the start of a used one
                target = $urandom_range(tbl_count - 1, 0);
                ad     = tbl_start[target];
                if (tbl_used[target])
                    ad = ad + 1;
            end
            else if (pick < 97 && n_used > 0)
            begin
                // one past the start of the last used segment
                for (k = 0; k < tbl_count; k++)
                    if (tbl_used[k])
                        ad = tbl_start[k] + 1;
            end
        end
    endtask

    task automatic test_random_traffic(int items, int send_pct, int recv_pct);
        int                   done;
        int                   batch;
        int                   n;
        logic                 f;
        logic [ADDR_BITS-1:0] sz;
        logic [ADDR_BITS-1:0] ad;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        done          = 0;
        while (done < items)
        begin
            case ($urandom_range(9))
                0: write_pool_size(16'hffff);
                1: write_pool_size(16'd1);
                2: write_pool_size(ADDR_BITS'($urandom));
                3: write_pool_size(16'd0);
                default: write_pool_size(ADDR_BITS'($urandom_range(160, 16)));
            endcase
            batch = $urandom_range(90, 40);
            for (n = 0; n < batch && done < items; n++)
            begin
                pick_request(f, sz, ad);
                send_request(f, sz, ad);
                done++;
            end
        end
        drain_results();
    endtask

    initial
    begin
        send_idle_pct = 37;
        recv_idle_pct = 46;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        pool_units = POOL_RESET;
        clear_table();
        test_basic_ops();
        test_pool_extremes();
        test_random_traffic(400, 37, 46);
        test_random_traffic(400, 46, 37);
        test_random_traffic(350, 0, 0);
        repeat (100) @(posedge clk);
        $display("%0d results checked over %0d pool settings", result_count, pool_writes);
        $display("ok %0d, no space %0d, not found %0d, table full %0d, zero size %0d",
                 status_seen[STAT_OK], status_seen[STAT_NO_SPACE],
                 status_seen[STAT_NOT_FOUND], status_seen[STAT_TABLE_FULL],
                 status_seen[STAT_ZERO_SIZE]);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
